[sv/prac_pkg.sv]
package prac_pkg;

    // Field and register widths fixed by the block
    localparam int ANGLE_BITS     = 10;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ANGLE    = 2'd0,
        REG_CENTER_X = 2'd1,
        REG_CENTER_Y = 2'd2
    } cfg_index_t;

    // Quadrant of the reduced angle
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Angle reduction constants and widths
    localparam int DEG_TWO_TURNS = 720;
    localparam int DEG_TURN      = 360;
    localparam int DEG_270       = 270;
    localparam int DEG_180       = 180;
    localparam int DEG_90        = 90;
    localparam int DEG_45        = 45;
    localparam int REM0_W        = ANGLE_BITS + 1;  // negated angle plus two turns
    localparam int REM1_W        = 10;              // 0..719
    localparam int DEG_W         = 9;               // 0..359
    localparam int QDEG_W        = 7;               // 0..89
    localparam int MAG_IDX_W     = 6;               // 0..45

    // First-octant magnitude table, 30 fraction bits of work precision
    localparam int          WORK_FRAC   = 30;
    localparam logic [63:0] PI_2P60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_PER_DEG = PI_2P60 / 64'd180;
    localparam int          MAG_ENTRIES = 46;
    localparam int          MAG_W       = 31;

    typedef logic [MAG_W-1:0] mag_tab_t [MAG_ENTRIES];

    function automatic logic [63:0] sq_step(logic [63:0] t, logic [63:0] x);
        logic [63:0] p;
        p = (t * x) >> WORK_FRAC;
        return (p * x) >> WORK_FRAC;
    endfunction

    // Taylor sine, every product and quotient truncated
    function automatic logic [63:0] sin30(logic [63:0] x);
        logic [63:0] t;
        logic [63:0] sum;
        t   = x;
        sum = x;
        t   = sq_step(t, x) / 64'd6;
        sum = sum - t;
        t   = sq_step(t, x) / 64'd20;
        sum = sum + t;
        t   = sq_step(t, x) / 64'd42;
        sum = sum - t;
        t   = sq_step(t, x) / 64'd72;
        sum = sum + t;
        t   = sq_step(t, x) / 64'd110;
        sum = sum - t;
        t   = sq_step(t, x) / 64'd156;
        sum = sum + t;
        return sum;
    endfunction

    // Taylor cosine, every product and quotient truncated
    function automatic logic [63:0] cos30(logic [63:0] x);
        logic [63:0] t;
        logic [63:0] sum;
        t   = 64'd1 << WORK_FRAC;
        sum = 64'd1 << WORK_FRAC;
        t   = sq_step(t, x) / 64'd2;
        sum = sum - t;
        t   = sq_step(t, x) / 64'd12;
        sum = sum + t;
        t   = sq_step(t, x) / 64'd30;
        sum = sum - t;
        t   = sq_step(t, x) / 64'd56;
        sum = sum + t;
        t   = sq_step(t, x) / 64'd90;
        sum = sum - t;
        t   = sq_step(t, x) / 64'd132;
        sum = sum + t;
        return sum;
    endfunction

    // Build the rounded magnitude table for one function at elaboration
    function automatic mag_tab_t build_mag(bit want_cos, int frac_bits);
        mag_tab_t    tab;
        logic [63:0] x;
        logic [63:0] v;
        int          sh;
        sh = WORK_FRAC - frac_bits;
        for (int d = 0; d < MAG_ENTRIES; d++)
        begin
            x = (64'(d) * RAD_PER_DEG + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
            v = want_cos ? cos30(x) : sin30(x);
            tab[d] = MAG_W'((v + (64'd1 << (sh - 1))) >> sh);
        end
        return tab;
    endfunction

endpackage

[sv/prac_trig.sv]
module prac_trig #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic signed [prac_pkg::ANGLE_BITS-1:0] angle,
    output logic signed [TRIG_FRAC_BITS+1:0]       cos_val,
    output logic signed [TRIG_FRAC_BITS+1:0]       sin_val
);
    import prac_pkg::*;

    localparam int       TRIG_W   = TRIG_FRAC_BITS + 2;
    localparam int       MAG_BITS = TRIG_FRAC_BITS + 1;
    localparam mag_tab_t COS_TAB  = build_mag(1'b1, TRIG_FRAC_BITS);
    localparam mag_tab_t SIN_TAB  = build_mag(1'b0, TRIG_FRAC_BITS);

    logic signed [ANGLE_BITS:0] neg_angle;
    logic [REM0_W-1:0]          rem0;
    logic [REM1_W-1:0]          rem1;
    logic [DEG_W-1:0]           red;
    quad_t                      quad;
    logic [QDEG_W-1:0]          oct_m;
    logic                       swap;
    logic [MAG_IDX_W-1:0]       idx;
    logic [MAG_BITS-1:0]        mag_c;
    logic [MAG_BITS-1:0]        mag_s;
    logic signed [TRIG_W-1:0]   cbs;
    logic signed [TRIG_W-1:0]   sbs;

    // Negate and reduce to 0..359 with two compare-subtract steps
    always_comb
    begin
        neg_angle = -((ANGLE_BITS + 1)'(angle));
        rem0      = REM0_W'(neg_angle) + REM0_W'(DEG_TWO_TURNS);
        rem1      = (rem0 >= REM0_W'(DEG_TWO_TURNS)) ? REM1_W'(rem0 - REM0_W'(DEG_TWO_TURNS))
                                                     : REM1_W'(rem0);
        red       = (rem1 >= REM1_W'(DEG_TURN)) ? DEG_W'(rem1 - REM1_W'(DEG_TURN))
                                                : DEG_W'(rem1);
    end

    // Split into quadrant and angle within the quadrant
    always_comb
    begin
        priority if (red >= DEG_W'(DEG_270))
        begin
            quad  = QUAD_3;
            oct_m = QDEG_W'(red - DEG_W'(DEG_270));
        end
        else if (red >= DEG_W'(DEG_180))
        begin
            quad  = QUAD_2;
            oct_m = QDEG_W'(red - DEG_W'(DEG_180));
        end
        else if (red >= DEG_W'(DEG_90))
        begin
            quad  = QUAD_1;
            oct_m = QDEG_W'(red - DEG_W'(DEG_90));
        end
        else
        begin
            quad  = QUAD_0;
            oct_m = QDEG_W'(red);
        end
    end

    // Fold the upper octant onto the table by swapping sine and cosine
    always_comb
    begin
        swap  = oct_m > QDEG_W'(DEG_45);
        idx   = swap ? MAG_IDX_W'(QDEG_W'(DEG_90) - oct_m) : MAG_IDX_W'(oct_m);
        mag_c = swap ? SIN_TAB[idx][MAG_BITS-1:0] : COS_TAB[idx][MAG_BITS-1:0];
        mag_s = swap ? COS_TAB[idx][MAG_BITS-1:0] : SIN_TAB[idx][MAG_BITS-1:0];
        cbs   = signed'({1'b0, mag_c});
        sbs   = signed'({1'b0, mag_s});
    end

    // Apply quadrant signs
    always_comb
    begin
        unique case (quad)
            QUAD_0:
            begin
                cos_val = cbs;
                sin_val = sbs;
            end
            QUAD_1:
            begin
                cos_val = -sbs;
                sin_val = cbs;
            end
            QUAD_2:
            begin
                cos_val = -cbs;
                sin_val = -sbs;
            end
            default:
            begin
                cos_val = sbs;
                sin_val = -cbs;
            end
        endcase
    end

endmodule

[sv/prac_cfg.sv]
module prac_cfg #(
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 16,
    parameter int CFG_DATA_W     = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [prac_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
    output logic signed [TRIG_FRAC_BITS+1:0]      cos_val,
    output logic signed [TRIG_FRAC_BITS+1:0]      sin_val,
    output logic signed [COORD_BITS-1:0]          center_x,
    output logic signed [COORD_BITS-1:0]          center_y
);
    import prac_pkg::*;

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;

    logic signed [TRIG_W-1:0]     wr_cos;
    logic signed [TRIG_W-1:0]     wr_sin;
    logic signed [TRIG_W-1:0]     cos_reg;
    logic signed [TRIG_W-1:0]     cos_next;
    logic signed [TRIG_W-1:0]     sin_reg;
    logic signed [TRIG_W-1:0]     sin_next;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_x_next;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic signed [COORD_BITS-1:0] center_y_next;

    // Look up cosine and sine of the angle being written
    prac_trig #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_trig (
        .angle  (cfg_wdata[ANGLE_BITS-1:0]),
        .cos_val(wr_cos),
        .sin_val(wr_sin)
    );

    // Decode register writes; unknown indexes are dropped
    always_comb
    begin
        cos_next      = cos_reg;
        sin_next      = sin_reg;
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ANGLE:
                begin
                    cos_next = wr_cos;
                    sin_next = wr_sin;
                end
                REG_CENTER_X: center_x_next = cfg_wdata[COORD_BITS-1:0];
                REG_CENTER_Y: center_y_next = cfg_wdata[COORD_BITS-1:0];
                default:
                begin
                    cos_next = cos_reg;
                end
            endcase
        end
    end

    // Hold settings; reset means zero angle and center at origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= TRIG_W'(1) <<< TRIG_FRAC_BITS;
            sin_reg      <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else
        begin
            cos_reg      <= cos_next;
            sin_reg      <= sin_next;
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

    assign cos_val  = cos_reg;
    assign sin_val  = sin_reg;
    assign center_x = center_x_reg;
    assign center_y = center_y_reg;

endmodule

[sv/prac_finish.sv]
module prac_finish #(
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic signed [COORD_BITS+TRIG_FRAC_BITS+3:0] acc,
    input  logic signed [COORD_BITS-1:0]                center,
    output logic signed [COORD_BITS-1:0]                value,
    output logic                                        clip
);
    localparam int ACC_W = COORD_BITS + TRIG_FRAC_BITS + 4;
    localparam int SHR_W = COORD_BITS + 4;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [SHR_W-1:0] LO   = SHR_W'(-(2 ** (COORD_BITS - 1)));
    localparam logic signed [SHR_W-1:0] HI   = SHR_W'(2 ** (COORD_BITS - 1) - 1);

    logic signed [ACC_W-1:0] sum_w;
    logic signed [SHR_W-1:0] flo;

    // Add center and one half, floor, then saturate
    always_comb
    begin
        sum_w = acc + (ACC_W'(center) <<< TRIG_FRAC_BITS) + HALF;
        flo   = SHR_W'(sum_w >>> TRIG_FRAC_BITS);
        priority if (flo < LO)
        begin
            value = COORD_BITS'(LO);
            clip  = 1'b1;
        end
        else if (flo > HI)
        begin
            value = COORD_BITS'(HI);
            clip  = 1'b1;
        end
        else
        begin
            value = COORD_BITS'(flo);
            clip  = 1'b0;
        end
    end

endmodule

[sv/prac_datapath.sv]
module prac_datapath #(
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_BITS-1:0]     in_px,
    input  logic signed [COORD_BITS-1:0]     in_py,
    input  logic                             in_last,
    input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
    input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    input  logic signed [COORD_BITS-1:0]     center_x,
    input  logic signed [COORD_BITS-1:0]     center_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [COORD_BITS-1:0]     out_rx,
    output logic signed [COORD_BITS-1:0]     out_ry,
    output logic                             out_last,
    output logic                             out_clip
);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = COORD_BITS + TRIG_FRAC_BITS + 3;
    localparam int ACC_W  = PROD_W + 1;

    logic                         a_ready;
    logic                         b_ready;
    logic                         o_ready;
    logic                         a_valid_reg;
    logic                         a_valid_next;
    logic                         b_valid_reg;
    logic                         b_valid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic signed [COORD_BITS-1:0] px_a_reg;
    logic signed [COORD_BITS-1:0] py_a_reg;
    logic                         last_a_reg;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    logic signed [PROD_W-1:0]     xc_next;
    logic signed [PROD_W-1:0]     ys_next;
    logic signed [PROD_W-1:0]     xs_next;
    logic signed [PROD_W-1:0]     yc_next;
    logic signed [PROD_W-1:0]     xc_reg;
    logic signed [PROD_W-1:0]     ys_reg;
    logic signed [PROD_W-1:0]     xs_reg;
    logic signed [PROD_W-1:0]     yc_reg;
    logic                         last_b_reg;
    logic signed [ACC_W-1:0]      acc_x;
    logic signed [ACC_W-1:0]      acc_y;
    logic signed [COORD_BITS-1:0] rx_next;
    logic signed [COORD_BITS-1:0] ry_next;
    logic                         clip_x;
    logic                         clip_y;
    logic signed [COORD_BITS-1:0] rx_reg;
    logic signed [COORD_BITS-1:0] ry_reg;
    logic                         last_reg;
    logic                         clip_reg;

    // Each stage takes a beat when empty or when its contents move on
    always_comb
    begin
        o_ready        = !out_valid_reg || out_ready;
        b_ready        = !b_valid_reg || o_ready;
        a_ready        = !a_valid_reg || b_ready;
        a_valid_next   = a_ready ? in_valid : a_valid_reg;
        b_valid_next   = b_ready ? a_valid_reg : b_valid_reg;
        out_valid_next = o_ready ? b_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Offsets from the center, the four products and their two sums
    always_comb
    begin
        dx      = DIFF_W'(px_a_reg) - DIFF_W'(center_x);
        dy      = DIFF_W'(py_a_reg) - DIFF_W'(center_y);
        xc_next = PROD_W'(dx) * PROD_W'(cos_val);
        ys_next = PROD_W'(dy) * PROD_W'(sin_val);
        xs_next = PROD_W'(dx) * PROD_W'(sin_val);
        yc_next = PROD_W'(dy) * PROD_W'(cos_val);
        acc_x   = ACC_W'(xc_reg) - ACC_W'(ys_reg);
        acc_y   = ACC_W'(xs_reg) + ACC_W'(yc_reg);
    end

    // Round and saturate both coordinates
    prac_finish #(
        .COORD_BITS    (COORD_BITS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_finish_x (
        .acc   (acc_x),
        .center(center_x),
        .value (rx_next),
        .clip  (clip_x)
    );

    prac_finish #(
        .COORD_BITS    (COORD_BITS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_finish_y (
        .acc   (acc_y),
        .center(center_y),
        .value (ry_next),
        .clip  (clip_y)
    );

    // Payload registers advance with their stage
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            px_a_reg   <= in_px;
            py_a_reg   <= in_py;
            last_a_reg <= in_last;
        end
        if (b_ready && a_valid_reg)
        begin
            xc_reg     <= xc_next;
            ys_reg     <= ys_next;
            xs_reg     <= xs_next;
            yc_reg     <= yc_next;
            last_b_reg <= last_a_reg;
        end
        if (o_ready && b_valid_reg)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            last_reg <= last_b_reg;
            clip_reg <= clip_x || clip_y;
        end
    end

    assign in_ready  = a_ready;
    assign out_valid = out_valid_reg;
    assign out_rx    = rx_reg;
    assign out_ry    = ry_reg;
    assign out_last  = last_reg;
    assign out_clip  = clip_reg;

endmodule

[sv/point_rotate_about_center_top.sv]
// Point rotation about a programmable center.
// Input stream (s_axis): one point per beat, x and y in tdata, tlast marks the
// final vertex of a figure. Output stream (m_axis): the rotated point per beat,
// tlast copied from the input, tuser set when either coordinate saturated.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high:
// 0 angle in whole degrees, 1 center x, 2 center y; other indexes are ignored.
// Writing the angle looks up cosine and sine in the first-octant table at once.
// An accepted beat passes the input, product and result registers in that
// order before it is presented on m_axis. Throughput: one point per cycle
// unless m_axis stalls; each stage holds one beat and loads again whenever its
// contents move on, so a stalled result still lets earlier stages fill. Three
// beats can be in flight before s_axis_tready drops.
// When the receiver stalls, the result and its flags hold until taken.
// Reset clears all valid flags and sets angle zero and center at the origin;
// there is no clearing pass and the block accepts points right after reset.
module point_rotate_about_center_top #(
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // point_x [COORD_BITS-1:0], point_y next, zero pad to bytes
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic                                        s_axis_tlast,
    // rotated_x [COORD_BITS-1:0], rotated_y next, zero pad to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic                                        m_axis_tlast,
    // clipped
    output logic [0:0]                                  m_axis_tuser,
    input  logic                                        cfg_we,
    input  logic [prac_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [((COORD_BITS > prac_pkg::ANGLE_BITS) ? COORD_BITS
                   : prac_pkg::ANGLE_BITS)-1:0]         cfg_wdata
);
    import prac_pkg::*;

    localparam int DATA_W     = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int PAD_W      = DATA_W - 2 * COORD_BITS;
    localparam int CFG_DATA_W = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;
    localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic signed [TRIG_W-1:0]     cos_val;
    logic signed [TRIG_W-1:0]     sin_val;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] rot_x;
    logic signed [COORD_BITS-1:0] rot_y;

    // Settings and trig values
    prac_cfg #(
        .COORD_BITS    (COORD_BITS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
        .CFG_DATA_W    (CFG_DATA_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cos_val  (cos_val),
        .sin_val  (sin_val),
        .center_x (center_x),
        .center_y (center_y)
    );

    // Rotation pipeline
    prac_datapath #(
        .COORD_BITS    (COORD_BITS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_px    (s_axis_tdata[COORD_BITS-1:0]),
        .in_py    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_last  (s_axis_tlast),
        .cos_val  (cos_val),
        .sin_val  (sin_val),
        .center_x (center_x),
        .center_y (center_y),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_rx   (rot_x),
        .out_ry   (rot_y),
        .out_last (m_axis_tlast),
        .out_clip (m_axis_tuser[0])
    );

    // Pack the result beat
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_axis_tdata = {{PAD_W{1'b0}}, rot_y, rot_x};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {rot_y, rot_x};
        end
    endgenerate

`ifndef SYNTHESIS
    // Input backpressure only comes from a full pipeline behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // A clipped result has at least one coordinate on a range bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (rot_x == COORD_MIN || rot_x == COORD_MAX ||
         rot_y == COORD_MIN || rot_y == COORD_MAX))
        else $error("clip flag set with both coordinates inside range");

    // Cosine and sine never vanish together
    assert property (@(posedge clk) disable iff (!rst_n)
        (cos_val != '0) || (sin_val != '0))
        else $error("trig lookup gave zero cosine and zero sine");
`endif

endmodule

[verif/point_rotate_about_center_top_tb.sv]
module point_rotate_about_center_top_tb;
    import prac_pkg::*;

    localparam int COORD_W          = 12;
    localparam int FRAC_W           = 16;
    localparam int DATA_W           = 24;
    localparam int CFG_W            = 12;
    localparam int CLK_HALF         = 2;
    localparam int LIMIT_CYCLES     = 400000;
    localparam int PHASES           = 12;
    localparam int POINTS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES     = 8;

    // Index that maps to no register; writes to it must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    // Fixed-point constants for the cosine and sine table
    localparam int          SERIES_FRAC     = 30;
    localparam logic [63:0] ONE_Q30         = 64'd1 << SERIES_FRAC;
    localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_PER_DEG_Q60 = PI_Q60 / 64'd180;
    localparam longint      COORD_MIN       = -(longint'(1) << (COORD_W - 1));
    localparam longint      COORD_MAX       = (longint'(1) << (COORD_W - 1)) - 1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               clip;
    } rot_point_t;

    // Rotation predictor plus the queue of rotated points still owed by the block
    class point_rotation_tracker;
        logic [ANGLE_BITS-1:0] angle;
        logic [COORD_W-1:0]    cen_x;
        logic [COORD_W-1:0]    cen_y;
        rot_point_t            expected_points[$];
        int                    mismatches;
        int                    points_checked;

        function new();
            angle          = '0;
            cen_x          = '0;
            cen_y          = '0;
            mismatches     = 0;
            points_checked = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_ANGLE:    angle = val[ANGLE_BITS-1:0];
                REG_CENTER_X: cen_x = val[COORD_W-1:0];
                REG_CENTER_Y: cen_y = val[COORD_W-1:0];
                default:      ;
            endcase
        endfunction

        // Truncated Taylor series, 30 fraction bits
        function logic [63:0] series_q30(bit want_cos, logic [63:0] x);
            logic [63:0] sum;
            logic [63:0] term;
            logic [63:0] div;
            sum  = want_cos ? ONE_Q30 : x;
            term = sum;
            for (int k = 1; k <= 6; k++)
            begin
                div  = want_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
                term = ((((term * x) >> SERIES_FRAC) * x) >> SERIES_FRAC) / div;
                sum  = (k % 2 == 1) ? sum - term : sum + term;
            end
            return sum;
        endfunction

        // First-octant magnitude, rounded half up to the table precision
        function longint octant_mag(bit want_cos, int deg);
            logic [63:0] x;
            logic [63:0] v;
            x = (64'(deg) * RAD_PER_DEG_Q60 + (64'd1 << (SERIES_FRAC - 1))) >> SERIES_FRAC;
            v = series_q30(want_cos, x);
            return longint'((v + (64'd1 << (SERIES_FRAC - FRAC_W - 1))) >> (SERIES_FRAC - FRAC_W));
        endfunction

        // Unfold the octant table over the full turn
        function void cos_sin(int r, output longint c, output longint s);
            quad_t  quad;
            int     m;
            longint cb;
            longint sb;
            quad = quad_t'(r / 90);
            m    = r % 90;
            if (m <= 45)
            begin
                cb = octant_mag(1'b1, m);
                sb = octant_mag(1'b0, m);
            end
            else
            begin
                cb = octant_mag(1'b0, 90 - m);
                sb = octant_mag(1'b1, 90 - m);
            end
            case (quad)
                QUAD_0:  begin c = cb;  s = sb;  end
                QUAD_1:  begin c = -sb; s = cb;  end
                QUAD_2:  begin c = -cb; s = -sb; end
                default: begin c = sb;  s = -cb; end
            endcase
        endfunction

        // Add the center back, round half up, saturate to the coordinate range
        function logic [COORD_W-1:0] round_sat(longint acc, longint cen, inout logic clip);
            longint v;
            v = (acc + cen * (longint'(1) << FRAC_W) + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
            if (v < COORD_MIN)
            begin
                v    = COORD_MIN;
                clip = 1'b1;
            end
            if (v > COORD_MAX)
            begin
                v    = COORD_MAX;
                clip = 1'b1;
            end
            return COORD_W'(v);
        endfunction

        function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic last);
            longint     ang;
            longint     cx;
            longint     cy;
            longint     dx;
            longint     dy;
            longint     c;
            longint     s;
            longint     r;
            logic       clip;
            rot_point_t e;
            ang = longint'($signed(angle));
            r   = (-ang) % 360;
            if (r < 0)
                r += 360;
            cos_sin(int'(r), c, s);
            cx     = longint'($signed(cen_x));
            cy     = longint'($signed(cen_y));
            dx     = longint'($signed(px)) - cx;
            dy     = longint'($signed(py)) - cy;
            clip   = 1'b0;
            e.x    = round_sat(dx * c - dy * s, cx, clip);
            e.y    = round_sat(dx * s + dy * c, cy, clip);
            e.last = last;
            e.clip = clip;
            expected_points.push_back(e);
        endfunction

        function void check_point(rot_point_t got);
            rot_point_t e;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected point: expected none, got %0d/%0d/%0b/%0b",
                         $time, $signed(got.x), $signed(got.y), got.last, got.clip);
                return;
            end
            e = expected_points.pop_front();
            points_checked++;
            if (got.x !== e.x || got.y !== e.y || got.last !== e.last || got.clip !== e.clip)
            begin
                mismatches++;
                $display("%0t mismatch: exp x/y/last/clip %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                         $time, $signed(e.x), $signed(e.y), e.last, e.clip,
                         $signed(got.x), $signed(got.y), got.last, got.clip);
            end
        endfunction
    endclass

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic [DATA_W-1:0]         s_axis_tdata  = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic                      s_axis_tlast  = 1'b0;
    logic [DATA_W-1:0]         m_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic                      m_axis_tlast;
    logic [0:0]                m_axis_tuser;
    logic                      cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]          cfg_wdata     = '0;

    point_rotation_tracker tracker = new();
    int send_idle_pct    = 38;
    int recv_idle_pct    = 75;
    int points_sent      = 0;
    int settings_applied = 0;

    point_rotate_about_center_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Check each result beat, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_point({m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W],
                                 m_axis_tlast, m_axis_tuser[0]});
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one point, idling first at random, and hold it until taken
    task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_point(px, py, last);
        points_sent++;
    endtask

    task automatic send_random_point(int cx, int cy);
        int                 kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        kind = $urandom_range(9);
        if (kind < 6)
        begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
        end
        else if (kind < 9)
        begin
            // near the center, where rounding dominates
            px = COORD_W'(cx + int'($urandom_range(128)) - 64);
            py = COORD_W'(cy + int'($urandom_range(128)) - 64);
        end
        else
        begin
            px = $urandom_range(1) ? 12'h7FF : 12'h800;
            py = $urandom_range(1) ? 12'h7FF : 12'h800;
        end
        send_point(px, py, $urandom_range(7) == 0);
    endtask

    // Drop valid and hold until every owed point is back and the pipe is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        tracker.set_register(idx, val);
    endtask

    // Load angle and center while idle; junk goes to the upper angle bits and the spare index
    task automatic program_setting(int angle_deg, int cx, int cy);
        wait_drained();
        write_reg(REG_ANGLE, {2'($urandom_range(3)), 10'(angle_deg)});
        write_reg(REG_CENTER_X, CFG_W'(cx));
        write_reg(REG_CENTER_Y, CFG_W'(cy));
        write_reg(REG_SPARE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        int ang;
        int cx;
        int cy;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: identity at the origin and at corners
        send_point(12'h000, 12'h000, 1'b0);
        send_point(12'h7FF, 12'h7FF, 1'b1);
        send_point(12'h800, 12'h800, 1'b0);
        send_point(12'h800, 12'h7FF, 1'b1);
        // Quarter turn about the origin; the lowest corner clips
        program_setting(90, 0, 0);
        send_point(12'h800, 12'h800, 1'b0);
        send_point(12'h7FF, 12'h000, 1'b1);
        send_point(12'h000, 12'h800, 1'b0);
        // Sixty degrees: halfway cases of the rounding
        program_setting(60, 0, 0);
        send_point(12'h001, 12'h000, 1'b0);
        send_point(12'h003, 12'h005, 1'b0);
        send_point(12'hFFF, 12'hFFD, 1'b1);
        // Eighth turn about a corner: the far corner clips in y, the center corner stays put
        program_setting(45, 2047, -2048);
        send_point(12'h800, 12'h7FF, 1'b0);
        send_point(12'h7FF, 12'h800, 1'b1);
        // Full turns and angles past the nominal range
        program_setting(-360, -2048, 2047);
        send_point(12'h7FF, 12'h800, 1'b0);
        program_setting(360, 0, 0);
        send_point(12'h123, 12'hABC, 1'b1);
        program_setting(511, 100, -100);
        send_point(12'h7FF, 12'h000, 1'b0);
        send_point(12'h800, 12'h456, 1'b1);
        program_setting(-512, -1, 1);
        send_point(12'h7FF, 12'h7FF, 1'b0);
        // Half turn: negation overflows at the lowest value
        program_setting(180, 0, 0);
        send_point(12'h800, 12'h800, 1'b0);
        send_point(12'h7FF, 12'h001, 1'b1);

        // Random phases, one setting each
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 75;
            end
            else if (p < 8)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0:       ang = 360;
                1:       ang = -360;
                2:       ang = 511;
                3:       ang = -512;
                4:       ang = 1;
                5:       ang = -45;
                6:       ang = 135;
                7:       ang = 0;
                default: ang = int'($urandom_range(1023)) - 512;
            endcase
            case (p % 4)
                0:
                begin
                    cx = -2048;
                    cy = -2048;
                end
                1:
                begin
                    cx = 2047;
                    cy = 2047;
                end
                2:
                begin
                    cx = int'($urandom_range(64)) - 32;
                    cy = int'($urandom_range(64)) - 32;
                end
                default:
                begin
                    cx = int'($urandom_range(4095)) - 2048;
                    cy = int'($urandom_range(4095)) - 2048;
                end
            endcase
            program_setting(ang, cx, cy);
            repeat (POINTS_PER_PHASE) send_random_point(cx, cy);
        end

        wait_drained();
        $display("summary: %0d points sent, %0d checked, %0d angle/center settings",
                 points_sent, tracker.points_checked, settings_applied);
        $display("summary: stalls on either side and none, extreme centers, angles past one turn");
        if (tracker.mismatches == 0 && tracker.expected_points.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
sv/prac_pkg.sv
sv/prac_trig.sv
sv/prac_cfg.sv
sv/prac_finish.sv
sv/prac_datapath.sv
sv/point_rotate_about_center_top.sv
verif/point_rotate_about_center_top_tb.sv
